@@ sv/psys_pkg.sv @@
// psys_pkg: shared types, constants and saturation helpers for the particle step block.
// Used by psys_front, psys_back and particle_system_step. No dependencies.
package psys_pkg;

  typedef enum logic {
    CMD_SPAWN = 1'b0,
    CMD_TICK  = 1'b1
  } cmd_kind_t;

  // register indexes of the configuration port
  localparam logic [1:0] CFG_ACCEL_X = 2'd0;
  localparam logic [1:0] CFG_ACCEL_Y = 2'd1;
  localparam logic [1:0] CFG_ACCEL_Z = 2'd2;

  localparam int unsigned MS_PER_SEC = 1000;

  typedef struct packed {
    cmd_kind_t          kind;
    logic               energy_zero;
    logic [15:0]        elapsed_ms;
    logic signed [31:0] start_x;
    logic signed [31:0] start_y;
    logic signed [31:0] start_z;
    logic signed [31:0] speed_x;
    logic signed [31:0] speed_y;
    logic signed [31:0] speed_z;
    logic [30:0]        life_energy;
    logic [30:0]        start_size;
    logic [16:0]        start_green;
  } cmd_t;

  // one stored particle, one memory word
  typedef struct packed {
    logic signed [31:0] px;
    logic signed [31:0] py;
    logic signed [31:0] pz;
    logic signed [31:0] vx;
    logic signed [31:0] vy;
    logic signed [31:0] vz;
    logic signed [31:0] energy;
    logic signed [31:0] size;
    logic signed [31:0] dsize;
    logic signed [31:0] green;
    logic signed [31:0] dgreen;
    logic signed [31:0] alpha;
    logic signed [31:0] dalpha;
  } part_t;

  function automatic logic signed [31:0] sat32(input logic signed [63:0] v);
    logic signed [31:0] r;
    if (v > 64'sd2147483647) r = 32'sh7fffffff;
    else if (v < -64'sd2147483648) r = 32'sh80000000;
    else r = v[31:0];
    return r;
  endfunction

  // a + b with b already scaled, saturated to 32 bits
  function automatic logic signed [31:0] add_sat(input logic signed [31:0] a,
                                                 input logic signed [63:0] b);
    logic signed [63:0] s;
    s = $signed({{32{a[31]}}, a}) + b;
    return sat32(s);
  endfunction

endpackage

@@ sv/psys_ram.sv @@
// psys_ram: generic single-write, single-read memory with registered read data.
// No dependencies.
module psys_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 64
) (
  input  logic                                  clk,
  input  logic                                  we,
  input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] waddr,
  input  logic [WIDTH-1:0]                      wdata,
  input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] raddr,
  output logic [WIDTH-1:0]                      rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

@@ sv/psys_div.sv @@
// psys_div: unsigned restoring divider, one quotient bit per cycle.
// No dependencies.
module psys_div #(
  parameter int NUM_W = 48,
  parameter int DEN_W = 32
) (
  input  logic             clk,
  input  logic             rst,
  input  logic             start,
  input  logic [NUM_W-1:0] num,
  input  logic [DEN_W-1:0] den,
  output logic             done,
  output logic [NUM_W-1:0] quot
);

  localparam int CNT_W = $clog2(NUM_W + 1);

  logic             busy;
  logic [CNT_W-1:0] cnt;
  logic [NUM_W-1:0] n;
  logic [DEN_W-1:0] d;
  logic [DEN_W-1:0] rem;
  logic [DEN_W:0]   shifted;
  logic             fits;

  assign shifted = {rem, n[NUM_W-1]};
  assign fits    = shifted >= {1'b0, d};

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
      cnt  <= '0;
    end else begin
      done <= 1'b0;
      if (start) begin
        busy <= 1'b1;
        cnt  <= CNT_W'(NUM_W);
        n    <= num;
        d    <= den;
        rem  <= '0;
        quot <= '0;
      end else if (busy) begin
        rem  <= fits ? DEN_W'(shifted - {1'b0, d}) : shifted[DEN_W-1:0];
        quot <= {quot[NUM_W-2:0], fits};
        n    <= n << 1;
        cnt  <= cnt - 1'b1;
        if (cnt == CNT_W'(1)) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

endmodule

@@ sv/psys_front.sv @@
// psys_front: takes input words, classifies them and queues them for the back end.
// Depends on psys_pkg.
module psys_front (
  input  logic               clk,
  input  logic               rst,
  input  logic               in_valid,
  output logic               in_ready,
  input  logic               kind,
  input  logic [15:0]        elapsed_ms,
  input  logic signed [31:0] start_x,
  input  logic signed [31:0] start_y,
  input  logic signed [31:0] start_z,
  input  logic signed [31:0] speed_x,
  input  logic signed [31:0] speed_y,
  input  logic signed [31:0] speed_z,
  input  logic [30:0]        life_energy,
  input  logic [30:0]        start_size,
  input  logic [16:0]        start_green,
  output logic               cmd_valid,
  input  logic               cmd_ready,
  output psys_pkg::cmd_t     cmd
);

  psys_pkg::cmd_t q [2];
  psys_pkg::cmd_t item;
  logic           head;
  logic           tail;
  logic [1:0]     fill;
  logic           push;
  logic           pop;

  always_comb begin
    item.kind        = kind ? psys_pkg::CMD_TICK : psys_pkg::CMD_SPAWN;
    item.energy_zero = (life_energy == '0);
    item.elapsed_ms  = elapsed_ms;
    item.start_x     = start_x;
    item.start_y     = start_y;
    item.start_z     = start_z;
    item.speed_x     = speed_x;
    item.speed_y     = speed_y;
    item.speed_z     = speed_z;
    item.life_energy = life_energy;
    item.start_size  = start_size;
    item.start_green = start_green;
  end

  assign in_ready  = (fill != 2'd2);
  assign cmd_valid = (fill != 2'd0);
  assign cmd       = q[head];
  assign push      = in_valid && in_ready;
  assign pop       = cmd_valid && cmd_ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      head <= 1'b0;
      tail <= 1'b0;
      fill <= 2'd0;
    end else begin
      if (push) begin
        q[tail] <= item;
        tail    <= ~tail;
      end
      if (pop) begin
        head <= ~head;
      end
      case ({push, pop})
        2'b10:   fill <= fill + 2'd1;
        2'b01:   fill <= fill - 2'd1;
        default: fill <= fill;
      endcase
    end
  end

endmodule

@@ sv/psys_back.sv @@
// psys_back: executes queued spawn and tick words against the particle memory.
// Depends on psys_pkg, psys_ram and psys_div.
module psys_back #(
  parameter int MAX_PARTICLES = 64,
  parameter int FRAC_BITS     = 16
) (
  input  logic               clk,
  input  logic               rst,
  input  logic signed [31:0] accel_x,
  input  logic signed [31:0] accel_y,
  input  logic signed [31:0] accel_z,
  input  logic               cmd_valid,
  output logic               cmd_ready,
  input  psys_pkg::cmd_t     cmd,
  output logic               out_valid,
  input  logic               out_ready,
  output logic               has_particle,
  output logic signed [31:0] out_x,
  output logic signed [31:0] out_y,
  output logic signed [31:0] out_z,
  output logic signed [31:0] out_size,
  output logic signed [31:0] out_green,
  output logic signed [31:0] out_alpha,
  output logic [6:0]         live_count,
  output logic               spawn_taken,
  output logic               is_last
);

  localparam int CW    = $clog2(MAX_PARTICLES + 1);
  localparam int IW    = MAX_PARTICLES > 1 ? $clog2(MAX_PARTICLES) : 1;
  localparam int NUM_W = 32 + FRAC_BITS;
  localparam int PW    = $bits(psys_pkg::part_t);

  // step length: ms * 2^FRAC_BITS / 1000 by reciprocal multiply, exact for 16-bit ms
  localparam int DT_SH = 26;
  localparam int DT_K  = FRAC_BITS + DT_SH;
  localparam int RW    = DT_K - 9;
  localparam int DPW   = 16 + RW;
  localparam logic [RW-1:0] DT_RECIP =
    RW'(((64'd1 << DT_K) + 64'(psys_pkg::MS_PER_SEC) - 64'd1) / 64'(psys_pkg::MS_PER_SEC));

  typedef enum logic [3:0] {
    S_IDLE, S_DIV, S_SPAWN_WR, S_RESULT, S_UPD_RD, S_UPD_MUL, S_UPD_WB,
    S_OUT_RD, S_OUT_WAIT, S_OUT_HOLD
  } state_t;

  typedef enum logic [1:0] {DS_SIZE, DS_GREEN, DS_ALPHA} div_sel_t;

  state_t             state;
  div_sel_t           sel;
  psys_pkg::cmd_t     cur;
  logic [CW-1:0]      count;
  logic [CW-1:0]      idx;
  logic [IW-1:0]      rd_addr;
  logic signed [31:0] dt;
  logic [DPW-1:0]     dt_prod;
  logic signed [31:0] dsize;
  logic signed [31:0] dgreen;

  logic               div_start;
  logic [NUM_W-1:0]   div_num;
  logic [31:0]        div_den;
  logic               div_done;
  logic [NUM_W-1:0]   div_quot;
  logic signed [31:0] rate;

  logic signed [63:0] p_vx, p_vy, p_vz, p_ax, p_ay, p_az, p_sz, p_gr, p_al;

  logic               ram_we;
  logic [IW-1:0]      ram_waddr;
  logic [IW-1:0]      ram_raddr;
  psys_pkg::part_t    ram_wdata;
  logic [PW-1:0]      ram_rdata;
  psys_pkg::part_t    rec;
  psys_pkg::part_t    upd;
  psys_pkg::part_t    born;
  logic               dies;

  psys_ram #(.WIDTH(PW), .DEPTH(MAX_PARTICLES)) u_ram (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (ram_wdata),
    .raddr (ram_raddr),
    .rdata (ram_rdata)
  );

  psys_div #(.NUM_W(NUM_W), .DEN_W(32)) u_div (
    .clk   (clk),
    .rst   (rst),
    .start (div_start),
    .num   (div_num),
    .den   (div_den),
    .done  (div_done),
    .quot  (div_quot)
  );

  assign rec = psys_pkg::part_t'(ram_rdata);

  assign dt_prod = {{RW{1'b0}}, cmd.elapsed_ms} * {16'd0, DT_RECIP};

  // negated quotient, saturated
  assign rate = (div_quot[NUM_W-1:31] != '0) ? 32'sh80000000
                                             : -$signed(div_quot[31:0]);

  always_comb begin
    upd        = rec;
    upd.px     = psys_pkg::add_sat(rec.px, p_vx >>> FRAC_BITS);
    upd.py     = psys_pkg::add_sat(rec.py, p_vy >>> FRAC_BITS);
    upd.pz     = psys_pkg::add_sat(rec.pz, p_vz >>> FRAC_BITS);
    upd.vx     = psys_pkg::add_sat(rec.vx, p_ax >>> FRAC_BITS);
    upd.vy     = psys_pkg::add_sat(rec.vy, p_ay >>> FRAC_BITS);
    upd.vz     = psys_pkg::add_sat(rec.vz, p_az >>> FRAC_BITS);
    upd.size   = psys_pkg::add_sat(rec.size, p_sz >>> FRAC_BITS);
    upd.green  = psys_pkg::add_sat(rec.green, p_gr >>> FRAC_BITS);
    upd.alpha  = psys_pkg::add_sat(rec.alpha, p_al >>> FRAC_BITS);
    upd.energy = psys_pkg::add_sat(rec.energy, -$signed({32'd0, dt}));
  end

  assign dies = (upd.energy <= 32'sd0);

  always_comb begin
    born.px     = cur.start_x;
    born.py     = cur.start_y;
    born.pz     = cur.start_z;
    born.vx     = cur.speed_x;
    born.vy     = cur.speed_y;
    born.vz     = cur.speed_z;
    born.energy = {1'b0, cur.life_energy};
    born.size   = {1'b0, cur.start_size};
    born.dsize  = dsize;
    born.green  = {15'd0, cur.start_green};
    born.dgreen = dgreen;
    born.alpha  = 32'sd1 <<< FRAC_BITS;
    born.dalpha = cur.energy_zero ? 32'sd0 : rate;
  end

  always_comb begin
    ram_we    = 1'b0;
    ram_waddr = idx[IW-1:0];
    ram_wdata = upd;
    case (state)
      S_SPAWN_WR: begin
        ram_we    = 1'b1;
        ram_waddr = count[IW-1:0];
        ram_wdata = born;
      end
      S_UPD_WB: ram_we = !dies;
      default:  ram_we = 1'b0;
    endcase
  end

  assign ram_raddr = (state == S_OUT_RD) ? idx[IW-1:0] : rd_addr;
  assign cmd_ready = (state == S_IDLE);

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      sel       <= DS_SIZE;
      count     <= '0;
      idx       <= '0;
      rd_addr   <= '0;
      div_start <= 1'b0;
      out_valid <= 1'b0;
    end else begin
      div_start <= 1'b0;
      case (state)
        S_IDLE: begin
          if (cmd_valid) begin
            cur <= cmd;
            if (cmd.kind == psys_pkg::CMD_TICK) begin
              dt      <= $signed(32'(dt_prod >> DT_SH));
              idx     <= '0;
              rd_addr <= '0;
              state   <= S_UPD_RD;
            end else if (count == CW'(MAX_PARTICLES)) begin
              has_particle <= 1'b0;
              {out_x, out_y, out_z, out_size, out_green, out_alpha} <= '0;
              live_count   <= 7'(count);
              spawn_taken  <= 1'b0;
              is_last      <= 1'b1;
              out_valid    <= 1'b1;
              state        <= S_RESULT;
            end else if (cmd.energy_zero) begin
              dsize  <= '0;
              dgreen <= '0;
              state  <= S_SPAWN_WR;
            end else begin
              sel       <= DS_SIZE;
              div_num   <= NUM_W'(cmd.start_size) << FRAC_BITS;
              div_den   <= 32'(cmd.life_energy);
              div_start <= 1'b1;
              state     <= S_DIV;
            end
          end
        end
        S_DIV: begin
          if (div_done) begin
            case (sel)
              DS_SIZE: begin
                dsize     <= rate;
                sel       <= DS_GREEN;
                div_num   <= NUM_W'(cur.start_green) << FRAC_BITS;
                div_den   <= {cur.life_energy, 1'b0};
                div_start <= 1'b1;
              end
              DS_GREEN: begin
                dgreen    <= rate;
                sel       <= DS_ALPHA;
                div_num   <= NUM_W'(1) << (2 * FRAC_BITS);
                div_den   <= 32'(cur.life_energy);
                div_start <= 1'b1;
              end
              default: state <= S_SPAWN_WR;
            endcase
          end
        end
        S_SPAWN_WR: begin
          count        <= count + 1'b1;
          has_particle <= 1'b0;
          {out_x, out_y, out_z, out_size, out_green, out_alpha} <= '0;
          live_count   <= 7'(count + 1'b1);
          spawn_taken  <= 1'b1;
          is_last      <= 1'b1;
          out_valid    <= 1'b1;
          state        <= S_RESULT;
        end
        S_RESULT: begin
          if (out_ready) begin
            out_valid <= 1'b0;
            state     <= S_IDLE;
          end
        end
        S_UPD_RD: begin
          if (idx == count) begin
            idx <= '0;
            if (count == '0) begin
              has_particle <= 1'b0;
              {out_x, out_y, out_z, out_size, out_green, out_alpha} <= '0;
              live_count   <= '0;
              spawn_taken  <= 1'b0;
              is_last      <= 1'b1;
              out_valid    <= 1'b1;
              state        <= S_RESULT;
            end else begin
              state <= S_OUT_RD;
            end
          end else begin
            state <= S_UPD_MUL;
          end
        end
        S_UPD_MUL: begin
          p_vx  <= rec.vx * dt;
          p_vy  <= rec.vy * dt;
          p_vz  <= rec.vz * dt;
          p_ax  <= accel_x * dt;
          p_ay  <= accel_y * dt;
          p_az  <= accel_z * dt;
          p_sz  <= rec.dsize * dt;
          p_gr  <= rec.dgreen * dt;
          p_al  <= rec.dalpha * dt;
          state <= S_UPD_WB;
        end
        S_UPD_WB: begin
          // a dead slot takes the last particle, which is advanced next
          if (dies) begin
            count   <= count - 1'b1;
            rd_addr <= IW'(count - 1'b1);
          end else begin
            idx     <= idx + 1'b1;
            rd_addr <= IW'(idx + 1'b1);
          end
          state <= S_UPD_RD;
        end
        S_OUT_RD: state <= S_OUT_WAIT;
        S_OUT_WAIT: begin
          has_particle <= 1'b1;
          out_x        <= rec.px;
          out_y        <= rec.py;
          out_z        <= rec.pz;
          out_size     <= rec.size;
          out_green    <= rec.green;
          out_alpha    <= rec.alpha;
          live_count   <= 7'(count);
          spawn_taken  <= 1'b0;
          is_last      <= (idx + 1'b1 == count);
          out_valid    <= 1'b1;
          state        <= S_OUT_HOLD;
        end
        S_OUT_HOLD: begin
          if (out_ready) begin
            out_valid <= 1'b0;
            if (is_last) begin
              state <= S_IDLE;
            end else begin
              idx   <= idx + 1'b1;
              state <= S_OUT_RD;
            end
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end

  a_count_bound: assert property (@(posedge clk) disable iff (rst)
    count <= CW'(MAX_PARTICLES))
    else $error("particle count above store size");

  a_out_state: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> (state == S_RESULT || state == S_OUT_HOLD))
    else $error("result shown outside a result state");

  a_div_state: assert property (@(posedge clk) disable iff (rst)
    div_done |-> state == S_DIV)
    else $error("quotient arrived while not waiting on it");

  a_take_idle: assert property (@(posedge clk) disable iff (rst)
    cmd_valid && cmd_ready |=> !out_valid || state == S_RESULT)
    else $error("new word taken while a tick stream was open");

endmodule

@@ sv/particle_system_step.sv @@
// Particle store with Euler tick update: front queue, divider and memory back end.
// Spawn: size, green and alpha rates from the bit-serial divider (one bit a cycle).
// Tick: the step length is registered, then each particle is read, updated and
// written back (one memory read a particle); results stream out, each held until taken.
// The front queue holds two words, so input is taken while the back end works.
// Reset (rst, synchronous) empties the store and clears the acceleration registers.
module particle_system_step #(
  parameter int MAX_PARTICLES = 64,
  parameter int FRAC_BITS     = 16
) (
  input  logic               clk,
  input  logic               rst,
  input  logic               cfg_we,
  input  logic [1:0]         cfg_index,
  input  logic [31:0]        cfg_data,
  input  logic               in_valid,
  output logic               in_ready,
  input  logic               kind,
  input  logic [15:0]        elapsed_ms,
  input  logic signed [31:0] start_x,
  input  logic signed [31:0] start_y,
  input  logic signed [31:0] start_z,
  input  logic signed [31:0] speed_x,
  input  logic signed [31:0] speed_y,
  input  logic signed [31:0] speed_z,
  input  logic [30:0]        life_energy,
  input  logic [30:0]        start_size,
  input  logic [16:0]        start_green,
  output logic               out_valid,
  input  logic               out_ready,
  output logic               has_particle,
  output logic signed [31:0] out_x,
  output logic signed [31:0] out_y,
  output logic signed [31:0] out_z,
  output logic signed [31:0] out_size,
  output logic signed [31:0] out_green,
  output logic signed [31:0] out_alpha,
  output logic [6:0]         live_count,
  output logic               spawn_taken,
  output logic               is_last
);

  logic signed [31:0] accel_x;
  logic signed [31:0] accel_y;
  logic signed [31:0] accel_z;
  logic               cmd_valid;
  logic               cmd_ready;
  psys_pkg::cmd_t     cmd;

  always_ff @(posedge clk) begin
    if (rst) begin
      accel_x <= '0;
      accel_y <= '0;
      accel_z <= '0;
    end else if (cfg_we) begin
      case (cfg_index)
        psys_pkg::CFG_ACCEL_X: accel_x <= cfg_data;
        psys_pkg::CFG_ACCEL_Y: accel_y <= cfg_data;
        psys_pkg::CFG_ACCEL_Z: accel_z <= cfg_data;
        default: ;
      endcase
    end
  end

  psys_front u_front (
    .clk         (clk),
    .rst         (rst),
    .in_valid    (in_valid),
    .in_ready    (in_ready),
    .kind        (kind),
    .elapsed_ms  (elapsed_ms),
    .start_x     (start_x),
    .start_y     (start_y),
    .start_z     (start_z),
    .speed_x     (speed_x),
    .speed_y     (speed_y),
    .speed_z     (speed_z),
    .life_energy (life_energy),
    .start_size  (start_size),
    .start_green (start_green),
    .cmd_valid   (cmd_valid),
    .cmd_ready   (cmd_ready),
    .cmd         (cmd)
  );

  psys_back #(.MAX_PARTICLES(MAX_PARTICLES), .FRAC_BITS(FRAC_BITS)) u_back (
    .clk          (clk),
    .rst          (rst),
    .accel_x      (accel_x),
    .accel_y      (accel_y),
    .accel_z      (accel_z),
    .cmd_valid    (cmd_valid),
    .cmd_ready    (cmd_ready),
    .cmd          (cmd),
    .out_valid    (out_valid),
    .out_ready    (out_ready),
    .has_particle (has_particle),
    .out_x        (out_x),
    .out_y        (out_y),
    .out_z        (out_z),
    .out_size     (out_size),
    .out_green    (out_green),
    .out_alpha    (out_alpha),
    .live_count   (live_count),
    .spawn_taken  (spawn_taken),
    .is_last      (is_last)
  );

endmodule
